// ----- design/bmb_pkg.sv -----
// shared types and constants for the block ring message buffer
package bmb_pkg;

    localparam int NUM_BLOCKS  = 8;
    localparam int BLOCK_BYTES = 4096;
    localparam int BLK_W       = $clog2(NUM_BLOCKS);
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int ADDR_W      = BLK_W + OFF_W;
    localparam int LEN_W       = 13;
    localparam int FREE_W      = 4;

    // opcodes as they arrive on the input
    localparam logic [2:0] OP_PUSH_START = 3'd0;
    localparam logic [2:0] OP_PUSH_BYTE  = 3'd1;
    localparam logic [2:0] OP_GET        = 3'd2;
    localparam logic [2:0] OP_READ_BYTE  = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    // item classes handed from front to back
    localparam logic [2:0] CLS_PUSH_START = 3'd0;
    localparam logic [2:0] CLS_PUSH_BYTE  = 3'd1;
    localparam logic [2:0] CLS_GET        = 3'd2;
    localparam logic [2:0] CLS_READ_BYTE  = 3'd3;
    localparam logic [2:0] CLS_CLEAR      = 3'd4;
    localparam logic [2:0] CLS_NOP        = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NEW_BLK  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_TOO_BIG  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [12:0] CAP_RESET = 13'd4092;

    typedef struct packed {
        logic [2:0]        cls;
        logic [LEN_W-1:0]  msg_length;
        logic [7:0]        data_byte;
        logic [2:0]        block_select;
        logic [11:0]       byte_offset;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [12:0]       got_length;
        logic [2:0]        payload_block;
        logic [11:0]       payload_offset;
        logic [7:0]        read_value;
        logic [3:0]        free_count;
        logic              read_ready;
    } result_t;

endpackage

// ----- design/bmb_front.sv -----
// front part: accepts and classifies input transactions into a short queue
module bmb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           opcode,
    input  logic [12:0]          msg_length,
    input  logic [7:0]           data_byte,
    input  logic [2:0]           block_select,
    input  logic [11:0]          byte_offset,
    output logic                 item_valid,
    output bmb_pkg::item_t       item,
    input  logic                 item_take
);

    bmb_pkg::item_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    bmb_pkg::item_t cls_item;
    logic           do_push;
    logic           do_pop;

    // classify the opcode
    always_comb
    begin
        cls_item.msg_length   = msg_length;
        cls_item.data_byte    = data_byte;
        cls_item.block_select = block_select;
        cls_item.byte_offset  = byte_offset;
        unique case (opcode)
            bmb_pkg::OP_PUSH_START: cls_item.cls = bmb_pkg::CLS_PUSH_START;
            bmb_pkg::OP_PUSH_BYTE:  cls_item.cls = bmb_pkg::CLS_PUSH_BYTE;
            bmb_pkg::OP_GET:        cls_item.cls = bmb_pkg::CLS_GET;
            bmb_pkg::OP_READ_BYTE:  cls_item.cls = bmb_pkg::CLS_READ_BYTE;
            bmb_pkg::OP_CLEAR:      cls_item.cls = bmb_pkg::CLS_CLEAR;
            default:                cls_item.cls = bmb_pkg::CLS_NOP;
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls_item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- design/bmb_back.sv -----
// back part: carries out one classified transaction at a time on the ring state
module bmb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [12:0]          cfg_wdata,
    input  logic                 item_valid,
    input  bmb_pkg::item_t       item,
    output logic                 item_take,
    input  logic                 res_room,
    output logic                 res_push,
    output bmb_pkg::result_t     res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PS_A = 4'd1;
    localparam logic [3:0] S_PS_B = 4'd2;
    localparam logic [3:0] S_WH1  = 4'd3;
    localparam logic [3:0] S_WH2  = 4'd4;
    localparam logic [3:0] S_PB   = 4'd5;
    localparam logic [3:0] S_G_A  = 4'd6;
    localparam logic [3:0] S_G_B  = 4'd7;
    localparam logic [3:0] S_G_R  = 4'd8;
    localparam logic [3:0] S_G_H  = 4'd9;
    localparam logic [3:0] S_G_L  = 4'd10;
    localparam logic [3:0] S_RB1  = 4'd11;
    localparam logic [3:0] S_RB2  = 4'd12;
    localparam logic [3:0] S_CLR  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    localparam int BLK_W  = bmb_pkg::BLK_W;
    localparam int OFF_W  = bmb_pkg::OFF_W;
    localparam int ADDR_W = bmb_pkg::ADDR_W;

    logic [3:0]         state_reg;
    bmb_pkg::item_t     item_reg;
    logic [12:0]        cap_reg;
    logic [BLK_W-1:0]   wc_reg;
    logic [BLK_W-1:0]   rc_reg;
    logic [3:0]         free_reg;
    logic               wfnz_reg;
    logic [BLK_W-1:0]   pend_blk_reg;
    logic [12:0]        pend_pos_reg;
    logic [12:0]        pend_left_reg;
    logic [12:0]        pos_reg;
    logic [7:0]         hi_reg;
    logic [2:0]         st_reg;
    logic [12:0]        gl_reg;
    logic [2:0]         pb_reg;
    logic [11:0]        po_reg;
    logic [7:0]         rv_reg;

    logic [12:0] fill_reg [bmb_pkg::NUM_BLOCKS];
    logic [12:0] wpos_reg [bmb_pkg::NUM_BLOCKS];
    logic [12:0] rpos_reg [bmb_pkg::NUM_BLOCKS];

    logic [7:0]        mem [bmb_pkg::NUM_BLOCKS * bmb_pkg::BLOCK_BYTES];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;

    logic              get_side;
    logic              next_side;
    logic [BLK_W-1:0]  base_idx;
    logic [BLK_W-1:0]  idx;
    logic [12:0]       fill_rd;
    logic [12:0]       wpos_rd;
    logic [12:0]       rpos_rd;
    logic [12:0]       cap;
    logic [14:0]       ts;
    logic [14:0]       fit_sum;
    logic [12:0]       glen;
    logic [12:0]       hdr_pos;

    // one shared index into the small per-block tables, chosen by state
    assign get_side  = (state_reg == S_G_A) || (state_reg == S_G_B) || (state_reg == S_G_R);
    assign next_side = (state_reg == S_PS_B) || (state_reg == S_G_B);
    assign base_idx  = get_side ? rc_reg : wc_reg;
    assign idx       = next_side ? base_idx + 1'b1 : base_idx;
    assign fill_rd   = fill_reg[idx];
    assign wpos_rd   = wpos_reg[idx];
    assign rpos_rd   = rpos_reg[idx];

    // fit check for push start
    assign cap     = (cap_reg < 13'(bmb_pkg::BLOCK_BYTES)) ? cap_reg
                                                            : 13'(bmb_pkg::BLOCK_BYTES);
    assign ts      = {2'b00, item_reg.msg_length} + 15'd2;
    assign fit_sum = {2'b00, fill_rd} + ts;
    assign glen    = {hi_reg[4:0], mem_rdata_reg};
    assign hdr_pos = pos_reg + 13'd1;

    // handshakes with front and result queue
    assign item_take = (state_reg == S_IDLE) && item_valid && res_room;
    assign res_push  = (state_reg == S_DONE);

    always_comb
    begin
        res.status         = st_reg;
        res.got_length     = gl_reg;
        res.payload_block  = pb_reg;
        res.payload_offset = po_reg;
        res.read_value     = rv_reg;
        res.free_count     = free_reg;
        res.read_ready     = (wc_reg != rc_reg) && wfnz_reg;
    end

    // byte store port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = {rc_reg, rpos_rd[OFF_W-1:0]};
        mem_wdata = item_reg.data_byte;
        unique case (state_reg)
            S_WH1:
            begin
                mem_we    = 1'b1;
                mem_addr  = {wc_reg, wpos_rd[OFF_W-1:0]};
                mem_wdata = {3'b000, item_reg.msg_length[12:8]};
            end
            S_WH2:
            begin
                mem_we    = 1'b1;
                mem_addr  = {wc_reg, hdr_pos[OFF_W-1:0]};
                mem_wdata = item_reg.msg_length[7:0];
            end
            S_PB:
            begin
                mem_we    = (pend_left_reg != 13'd0);
                mem_addr  = {pend_blk_reg, pend_pos_reg[OFF_W-1:0]};
            end
            S_G_H:
            begin
                mem_addr  = {rc_reg, hdr_pos[OFF_W-1:0]};
            end
            S_RB1:
            begin
                mem_addr  = {item_reg.block_select[BLK_W-1:0],
                             item_reg.byte_offset[OFF_W-1:0]};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // byte store, single port with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    // item payload latch
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
    end

    // sequencer and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= bmb_pkg::CAP_RESET;
            wc_reg        <= '0;
            rc_reg        <= '0;
            free_reg      <= 4'(bmb_pkg::NUM_BLOCKS);
            wfnz_reg      <= 1'b0;
            pend_blk_reg  <= '0;
            pend_pos_reg  <= '0;
            pend_left_reg <= '0;
            pos_reg       <= '0;
            hi_reg        <= '0;
            st_reg        <= '0;
            gl_reg        <= '0;
            pb_reg        <= '0;
            po_reg        <= '0;
            rv_reg        <= '0;
            for (int i = 0; i < bmb_pkg::NUM_BLOCKS; i++)
            begin
                fill_reg[i] <= '0;
                wpos_reg[i] <= '0;
                rpos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        st_reg <= bmb_pkg::ST_OK;
                        gl_reg <= '0;
                        pb_reg <= '0;
                        po_reg <= '0;
                        rv_reg <= '0;
                        unique case (item.cls)
                            bmb_pkg::CLS_PUSH_START: state_reg <= S_PS_A;
                            bmb_pkg::CLS_PUSH_BYTE:  state_reg <= S_PB;
                            bmb_pkg::CLS_GET:        state_reg <= S_G_A;
                            bmb_pkg::CLS_READ_BYTE:  state_reg <= S_RB1;
                            bmb_pkg::CLS_CLEAR:      state_reg <= S_CLR;
                            default:                 state_reg <= S_DONE;
                        endcase
                    end
                end
                // does the message fit the current write block
                S_PS_A:
                begin
                    pend_left_reg <= '0;
                    if (fit_sum <= {2'b00, cap})
                    begin
                        state_reg <= S_WH1;
                    end
                    else if (ts > {2'b00, cap})
                    begin
                        st_reg    <= bmb_pkg::ST_TOO_BIG;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_PS_B;
                    end
                end
                // advance only into an empty block
                S_PS_B:
                begin
                    if (fill_rd == 13'd0)
                    begin
                        wc_reg        <= idx;
                        wpos_reg[idx] <= '0;
                        rpos_reg[idx] <= '0;
                        if (free_reg != 4'd0)
                        begin
                            free_reg <= free_reg - 4'd1;
                        end
                        st_reg    <= bmb_pkg::ST_NEW_BLK;
                        state_reg <= S_WH1;
                    end
                    else
                    begin
                        st_reg    <= bmb_pkg::ST_FULL;
                        state_reg <= S_DONE;
                    end
                end
                // header high byte written, latch write position
                S_WH1:
                begin
                    pos_reg   <= wpos_rd;
                    state_reg <= S_WH2;
                end
                // header low byte written, commit the message
                S_WH2:
                begin
                    pend_blk_reg     <= wc_reg;
                    pend_pos_reg     <= pos_reg + 13'd2;
                    pend_left_reg    <= item_reg.msg_length;
                    wpos_reg[wc_reg] <= pos_reg + ts[12:0];
                    fill_reg[wc_reg] <= fill_rd + ts[12:0];
                    wfnz_reg         <= 1'b1;
                    state_reg        <= S_DONE;
                end
                S_PB:
                begin
                    if (pend_left_reg != 13'd0)
                    begin
                        pend_pos_reg  <= pend_pos_reg + 13'd1;
                        pend_left_reg <= pend_left_reg - 13'd1;
                    end
                    state_reg <= S_DONE;
                end
                // current read block exhausted?
                S_G_A:
                begin
                    state_reg <= (rpos_rd == wpos_rd) ? S_G_B : S_G_R;
                end
                S_G_B:
                begin
                    if (rpos_rd < wpos_rd)
                    begin
                        rc_reg    <= idx;
                        st_reg    <= bmb_pkg::ST_NEW_BLK;
                        state_reg <= S_G_R;
                    end
                    else
                    begin
                        st_reg    <= bmb_pkg::ST_EMPTY;
                        state_reg <= S_DONE;
                    end
                end
                // header reads
                S_G_R:
                begin
                    pos_reg   <= rpos_rd;
                    state_reg <= S_G_H;
                end
                S_G_H:
                begin
                    hi_reg    <= mem_rdata_reg;
                    state_reg <= S_G_L;
                end
                S_G_L:
                begin
                    gl_reg           <= glen;
                    pb_reg           <= 3'(rc_reg);
                    po_reg           <= 12'(pos_reg + 13'd2);
                    rpos_reg[rc_reg] <= pos_reg + 13'd2 + glen;
                    state_reg        <= S_DONE;
                end
                S_RB1:
                begin
                    state_reg <= S_RB2;
                end
                S_RB2:
                begin
                    rv_reg    <= mem_rdata_reg;
                    state_reg <= S_DONE;
                end
                S_CLR:
                begin
                    for (int i = 0; i < bmb_pkg::NUM_BLOCKS; i++)
                    begin
                        fill_reg[i] <= '0;
                        wpos_reg[i] <= '0;
                        rpos_reg[i] <= '0;
                    end
                    wc_reg        <= '0;
                    rc_reg        <= '0;
                    wfnz_reg      <= 1'b0;
                    pend_blk_reg  <= '0;
                    pend_pos_reg  <= '0;
                    pend_left_reg <= '0;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/bmb_rqueue.sv -----
// result queue: holds finished results until popped
module bmb_rqueue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_push,
    input  bmb_pkg::result_t     res,
    output logic                 res_room,
    output logic                 empty,
    input  logic                 pop,
    output bmb_pkg::result_t     head
);

    bmb_pkg::result_t q_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_pop;

    assign res_room = (count_reg != 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = q_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    // result storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, res_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- design/block_ring_message_buffer_core.sv -----
// Block ring message buffer: 32 KiB byte store in 8 blocks of length-prefixed messages.
// The back sequencer carries out one transaction at a time, taking no new one until the
// last has gone to the result queue; its byte store port takes one access a cycle
// (push start writes two header bytes).
// Reset clears cursors, block tables and queues at once; the byte store is not cleared.
module block_ring_message_buffer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [2:0]    opcode,
    input  logic [12:0]   msg_length,
    input  logic [7:0]    data_byte,
    input  logic [2:0]    block_select,
    input  logic [11:0]   byte_offset,
    output logic          empty,
    input  logic          pop,
    output logic [2:0]    status,
    output logic [12:0]   got_length,
    output logic [2:0]    payload_block,
    output logic [11:0]   payload_offset,
    output logic [7:0]    read_value,
    output logic [3:0]    free_count,
    output logic          read_ready,
    input  logic          cfg_we,
    input  logic [12:0]   cfg_wdata
);

    logic             item_valid;
    bmb_pkg::item_t   item;
    logic             item_take;
    logic             res_room;
    logic             res_push;
    bmb_pkg::result_t res;
    bmb_pkg::result_t head;

    // front: accept and classify
    bmb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .msg_length   (msg_length),
        .data_byte    (data_byte),
        .block_select (block_select),
        .byte_offset  (byte_offset),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    // back: execute on ring state
    bmb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_room   (res_room),
        .res_push   (res_push),
        .res        (res)
    );

    // results out
    bmb_rqueue u_rqueue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign status         = head.status;
    assign got_length     = head.got_length;
    assign payload_block  = head.payload_block;
    assign payload_offset = head.payload_offset;
    assign read_value     = head.read_value;
    assign free_count     = head.free_count;
    assign read_ready     = head.read_ready;

endmodule
